// File: sv/prc_pkg.sv
// ---------------------------------------------------------------------------
// prc_pkg
// Shared types, constants and the arc-tangent table for the point rotation
// pipeline.
// ---------------------------------------------------------------------------
package prc_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int ANGLE_W = 18;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int GUARD   = 24;
    // CORDIC datapath: difference times gain inverse plus growth margin
    localparam int VEC_W   = 51;
    localparam int ANG_W   = 26;

    // Stage count, limited by the table length
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int CORDIC_RUN    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int IDX_W         = 5;

    // Degrees with 8 fractional bits
    localparam logic signed [19:0] DEG_90      = 20'sd23040;
    localparam logic signed [19:0] DEG_180     = 20'sd46080;
    localparam logic signed [19:0] DEG_270     = 20'sd69120;
    localparam logic signed [19:0] DEG_360     = 20'sd92160;
    localparam logic signed [19:0] DEG_360_NEG = -20'sd92160;
    localparam logic signed [19:0] DEG_720     = 20'sd184320;

    // 1 / CORDIC gain, 24 fractional bits
    localparam logic signed [DIFF_W-1:0] GAIN_INV = 25'sd10188014;

    localparam logic signed [COORD_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] OUT_MIN = 24'sh800000;

    // Word traveling down the CORDIC chain
    typedef struct packed {
        logic signed [VEC_W-1:0]   x;
        logic signed [VEC_W-1:0]   y;
        logic signed [ANG_W-1:0]   z;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } prc_vec_t;

    // atan(2^-i) in degrees, 16 fractional bits
    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] r;
        begin
            case (idx)
                5'd0:    r = 26'sd2949120;
                5'd1:    r = 26'sd1740967;
                5'd2:    r = 26'sd919879;
                5'd3:    r = 26'sd466945;
                5'd4:    r = 26'sd234379;
                5'd5:    r = 26'sd117304;
                5'd6:    r = 26'sd58666;
                5'd7:    r = 26'sd29335;
                5'd8:    r = 26'sd14668;
                5'd9:    r = 26'sd7334;
                5'd10:   r = 26'sd3667;
                5'd11:   r = 26'sd1833;
                5'd12:   r = 26'sd917;
                5'd13:   r = 26'sd458;
                5'd14:   r = 26'sd229;
                5'd15:   r = 26'sd115;
                5'd16:   r = 26'sd57;
                5'd17:   r = 26'sd29;
                5'd18:   r = 26'sd14;
                5'd19:   r = 26'sd7;
                5'd20:   r = 26'sd4;
                5'd21:   r = 26'sd2;
                5'd22:   r = 26'sd1;
                default: r = 26'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: sv/prc_prep.sv
// ---------------------------------------------------------------------------
// prc_prep
// Front end: subtracts the center, folds the angle into [-90, 90] degrees
// (negating the difference when a half turn is taken off), then scales the
// difference by the CORDIC gain inverse. Two register stages.
// ---------------------------------------------------------------------------
module prc_prep (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [prc_pkg::COORD_W-1:0]     point_x,
    input  logic signed [prc_pkg::COORD_W-1:0]     point_y,
    input  logic signed [prc_pkg::COORD_W-1:0]     center_x,
    input  logic signed [prc_pkg::COORD_W-1:0]     center_y,
    input  logic signed [prc_pkg::ANGLE_W-1:0]     angle_deg,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output prc_pkg::prc_vec_t                      out_data
);

    localparam int DIFF_W = prc_pkg::DIFF_W;

    logic signed [prc_pkg::DIFF_W-1:0] diff_x;
    logic signed [prc_pkg::DIFF_W-1:0] diff_y;
    logic signed [19:0]                ang_ext;
    logic signed [19:0]                ang_mod;
    logic signed [19:0]                ang_fold;
    logic                              flip;

    logic                              s1_valid_reg;
    logic signed [prc_pkg::DIFF_W-1:0] s1_dx_reg;
    logic signed [prc_pkg::DIFF_W-1:0] s1_dy_reg;
    logic signed [prc_pkg::ANG_W-1:0]  s1_z_reg;
    logic signed [prc_pkg::COORD_W-1:0] s1_cx_reg;
    logic signed [prc_pkg::COORD_W-1:0] s1_cy_reg;
    logic                              s1_ready;

    logic                              s2_valid_reg;
    logic                              s2_ready;
    prc_pkg::prc_vec_t                 s2_data_reg;
    prc_pkg::prc_vec_t                 s2_data_next;
    logic signed [2*prc_pkg::DIFF_W-1:0] prod_x;
    logic signed [2*prc_pkg::DIFF_W-1:0] prod_y;

    // angle modulo 360 into [0, 360)
    always_comb
    begin
        ang_ext = {{(20-prc_pkg::ANGLE_W){angle_deg[prc_pkg::ANGLE_W-1]}}, angle_deg};
        if (ang_ext < prc_pkg::DEG_360_NEG)
            ang_mod = ang_ext + prc_pkg::DEG_720;
        else if (ang_ext < 20'sd0)
            ang_mod = ang_ext + prc_pkg::DEG_360;
        else if (ang_ext >= prc_pkg::DEG_360)
            ang_mod = ang_ext - prc_pkg::DEG_360;
        else
            ang_mod = ang_ext;
    end

    // fold into [-90, 90]; the middle half turn flips the vector
    always_comb
    begin
        if (ang_mod <= prc_pkg::DEG_90)
        begin
            ang_fold = ang_mod;
            flip     = 1'b0;
        end
        else if (ang_mod < prc_pkg::DEG_270)
        begin
            ang_fold = ang_mod - prc_pkg::DEG_180;
            flip     = 1'b1;
        end
        else
        begin
            ang_fold = ang_mod - prc_pkg::DEG_360;
            flip     = 1'b0;
        end
    end

    // center-relative difference, negated on a half turn
    always_comb
    begin
        diff_x = DIFF_W'(point_x) - DIFF_W'(center_x);
        diff_y = DIFF_W'(point_y) - DIFF_W'(center_y);
        if (flip)
        begin
            diff_x = -diff_x;
            diff_y = -diff_y;
        end
    end

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage 1: difference and folded angle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    // folded angle fits in 18 bits, so the low bits carry the sign
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_dx_reg <= diff_x;
            s1_dy_reg <= diff_y;
            s1_z_reg  <= {ang_fold[prc_pkg::ANG_W-9:0], 8'd0};
            s1_cx_reg <= center_x;
            s1_cy_reg <= center_y;
        end
    end

    // stage 2: gain removal
    always_comb
    begin
        prod_x          = s1_dx_reg * prc_pkg::GAIN_INV;
        prod_y          = s1_dy_reg * prc_pkg::GAIN_INV;
        s2_data_next.x  = {prod_x[2*DIFF_W-1], prod_x};
        s2_data_next.y  = {prod_y[2*DIFF_W-1], prod_y};
        s2_data_next.z  = s1_z_reg;
        s2_data_next.cx = s1_cx_reg;
        s2_data_next.cy = s1_cy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
            s2_data_reg <= s2_data_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

// File: sv/prc_cell.sv
// ---------------------------------------------------------------------------
// prc_cell
// One CORDIC micro-rotation in rotation mode: turns the vector by
// +-atan(2^-idx) toward zero residual angle, then registers the word.
// ---------------------------------------------------------------------------
module prc_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [prc_pkg::IDX_W-1:0]         idx,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  prc_pkg::prc_vec_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output prc_pkg::prc_vec_t                 out_data
);

    logic                            valid_reg;
    prc_pkg::prc_vec_t               data_reg;
    prc_pkg::prc_vec_t               data_next;
    logic signed [prc_pkg::VEC_W-1:0] vx;
    logic signed [prc_pkg::VEC_W-1:0] vy;
    logic signed [prc_pkg::VEC_W-1:0] xs;
    logic signed [prc_pkg::VEC_W-1:0] ys;
    logic signed [prc_pkg::ANG_W-1:0] arc;

    // micro-rotation, floor shifts
    always_comb
    begin
        vx  = in_data.x;
        vy  = in_data.y;
        xs  = vx >>> idx;
        ys  = vy >>> idx;
        arc = prc_pkg::atan_lut(idx);
        data_next = in_data;
        if (!in_data.z[prc_pkg::ANG_W-1])
        begin
            data_next.x = vx - ys;
            data_next.y = vy + xs;
            data_next.z = in_data.z - arc;
        end
        else
        begin
            data_next.x = vx + ys;
            data_next.y = vy - xs;
            data_next.z = in_data.z + arc;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef ASSERT_OFF
    // a blocked word is kept, not dropped or overwritten
    a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("prc_cell: blocked word lost");
    // the cell takes a word whenever it is empty
    a_cell_take: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
        else $error("prc_cell: empty cell refused a word");
`endif

endmodule

// File: sv/prc_post.sv
// ---------------------------------------------------------------------------
// prc_post
// Back end: rounds the guard bits off the rotated vector, adds the center
// back and saturates to the coordinate width. One register stage.
// ---------------------------------------------------------------------------
module prc_post (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  prc_pkg::prc_vec_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [prc_pkg::COORD_W-1:0]  out_x,
    output logic signed [prc_pkg::COORD_W-1:0]  out_y
);

    localparam int VEC_W   = prc_pkg::VEC_W;
    localparam int GUARD   = prc_pkg::GUARD;
    localparam int COORD_W = prc_pkg::COORD_W;
    localparam int RND_W   = VEC_W - GUARD;
    localparam int SUM_W   = RND_W + 1;

    logic                          valid_reg;
    logic signed [COORD_W-1:0]     x_reg;
    logic signed [COORD_W-1:0]     y_reg;
    logic signed [COORD_W-1:0]     x_next;
    logic signed [COORD_W-1:0]     y_next;
    logic signed [VEC_W-1:0]       rnd_x;
    logic signed [VEC_W-1:0]       rnd_y;
    logic signed [SUM_W-1:0]       sum_x;
    logic signed [SUM_W-1:0]       sum_y;

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        begin
            if (v > SUM_W'(prc_pkg::OUT_MAX))
                r = prc_pkg::OUT_MAX;
            else if (v < SUM_W'(prc_pkg::OUT_MIN))
                r = prc_pkg::OUT_MIN;
            else
                r = v[COORD_W-1:0];
            return r;
        end
    endfunction

    // round to nearest, add center, clamp
    always_comb
    begin
        rnd_x  = in_data.x + (VEC_W'(1) <<< (GUARD - 1));
        rnd_y  = in_data.y + (VEC_W'(1) <<< (GUARD - 1));
        sum_x  = SUM_W'(signed'(rnd_x[VEC_W-1:GUARD])) + SUM_W'(in_data.cx);
        sum_y  = SUM_W'(signed'(rnd_y[VEC_W-1:GUARD])) + SUM_W'(in_data.cy);
        x_next = sat(sum_x);
        y_next = sat(sum_y);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

// File: sv/point_rotate_about_center.sv
// A word passes the two front-end stages, each CORDIC cell and the back-end stage on its way to the result.
// Throughput: one word per cycle while out_stall is low; each CORDIC cell is its own register stage.
// Every stage advances into a free slot, so bubbles close up while the output waits.
// Reset clears all valid flags asynchronously; the datapath registers are not reset.
// ---------------------------------------------------------------------------
// point_rotate_about_center
// Rotates a point about a center by an angle in degrees using an unrolled
// CORDIC chain; results saturate to the coordinate range.
// ---------------------------------------------------------------------------
module point_rotate_about_center (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [prc_pkg::COORD_W-1:0]  point_x,
    input  logic signed [prc_pkg::COORD_W-1:0]  point_y,
    input  logic signed [prc_pkg::COORD_W-1:0]  center_x,
    input  logic signed [prc_pkg::COORD_W-1:0]  center_y,
    input  logic signed [prc_pkg::ANGLE_W-1:0]  angle_deg,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [prc_pkg::COORD_W-1:0]  out_x,
    output logic signed [prc_pkg::COORD_W-1:0]  out_y
);

    localparam int NCELL = prc_pkg::CORDIC_RUN;

    logic                  prep_ready;
    logic                  chain_valid [NCELL+1];
    logic                  chain_ready [NCELL+1];
    prc_pkg::prc_vec_t     chain_data  [NCELL+1];

    // center removal, angle fold, gain removal
    prc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (prep_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .center_x  (center_x),
        .center_y  (center_y),
        .angle_deg (angle_deg),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    assign in_stall = !prep_ready;

    // CORDIC chain
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        prc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (prc_pkg::IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // rounding, center add, saturation
    prc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[NCELL]),
        .in_ready  (chain_ready[NCELL]),
        .in_data   (chain_data[NCELL]),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_x     (out_x),
        .out_y     (out_y)
    );

`ifndef ASSERT_OFF
    // input backs up only when the whole chain is full behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while pipeline has room");
    // a stalled result stays on the port
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y))
        else $error("stalled result changed");
    // an empty first cell always takes the front end's word
    a_chain_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !chain_valid[1] |-> chain_ready[0])
        else $error("empty first cell refused a word");
`endif

endmodule

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks point_rotate_about_center against a bit-exact CORDIC predictor.
// Directed words hit the field extremes, angle wrapping, quadrant flips and
// saturation. Random traffic then runs under three sender/receiver idle mixes.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [prc_pkg::COORD_W-1:0] coord_t;
    typedef logic signed [prc_pkg::ANGLE_W-1:0] angle_t;
    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    localparam longint DEG_FULL    = prc_pkg::DEG_360;
    localparam longint DEG_HALF    = prc_pkg::DEG_180;
    localparam longint DEG_QUARTER = prc_pkg::DEG_90;
    localparam longint OUT_HI      = 8388607;
    localparam longint OUT_LO      = -8388608;
    localparam int     PIPE_LAT    = prc_pkg::CORDIC_RUN + 3;
    localparam int     DRAIN_WAIT  = 2 * PIPE_LAT + 10;
    localparam int     CYCLE_LIMIT = 300000;
    localparam int     MAX_REPORTS = 10;

    // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
    longint atan_q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    coord_t point_x = '0;
    coord_t point_y = '0;
    coord_t center_x = '0;
    coord_t center_y = '0;
    angle_t angle_deg = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    coord_t out_x;
    coord_t out_y;

    point_t      rotated_q [$];
    int          error_count = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    point_rotate_about_center u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .center_x  (center_x),
        .center_y  (center_y),
        .angle_deg (angle_deg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y)
    );

    always #1 clk = ~clk;

    // Saturate to the coordinate range
    function automatic coord_t clamp_coord(input longint v);
        if (v > OUT_HI)
            return coord_t'(OUT_HI);
        if (v < OUT_LO)
            return coord_t'(OUT_LO);
        return coord_t'(v);
    endfunction

    // Rotate (p - c) by the angle with a 24-guard-bit CORDIC, then add c back
    function automatic point_t predict_rotation(input coord_t px, input coord_t py,
                                                input coord_t cx, input coord_t cy,
                                                input angle_t ang);
        longint vx;
        longint vy;
        longint deg;
        longint z;
        longint sx;
        longint sy;
        longint nx;
        longint half_lsb;
        int     i;
        point_t res;
        vx = (longint'(px) - longint'(cx)) * longint'(prc_pkg::GAIN_INV);
        vy = (longint'(py) - longint'(cy)) * longint'(prc_pkg::GAIN_INV);

        // wrap to (-180, 180], then fold into [-90, 90] with a half turn
        deg = longint'(ang) % DEG_FULL;
        if (deg < 0)
            deg += DEG_FULL;
        if (deg > DEG_HALF)
            deg -= DEG_FULL;
        if (deg > DEG_QUARTER)
        begin
            vx = -vx;
            vy = -vy;
            deg -= DEG_HALF;
        end
        else if (deg < -DEG_QUARTER)
        begin
            vx = -vx;
            vy = -vy;
            deg += DEG_HALF;
        end
        z = deg * 256;

        for (i = 0; i < prc_pkg::CORDIC_RUN; i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (z >= 0)
            begin
                nx = vx - sy;
                vy = vy + sx;
                z  = z - atan_q16[i];
            end
            else
            begin
                nx = vx + sy;
                vy = vy - sx;
                z  = z + atan_q16[i];
            end
            vx = nx;
        end

        // drop guard bits, round half up
        half_lsb = longint'(1) <<< (prc_pkg::GUARD - 1);
        vx = (vx + half_lsb) >>> prc_pkg::GUARD;
        vy = (vy + half_lsb) >>> prc_pkg::GUARD;
        res.x = clamp_coord(vx + longint'(cx));
        res.y = clamp_coord(vy + longint'(cy));
        return res;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Capture accepted words into the prediction queue, check accepted results
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                rotated_q.push_back(predict_rotation(point_x, point_y, center_x,
                                                     center_y, angle_deg));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (rotated_q.size() == 0)
                    note_error($sformatf("unexpected result x=%0d y=%0d", out_x, out_y));
                else
                begin
                    want = rotated_q.pop_front();
                    if (out_x !== want.x)
                        note_error($sformatf("out_x expected %0d got %0d", want.x, out_x));
                    if (out_y !== want.y)
                        note_error($sformatf("out_y expected %0d got %0d", want.y, out_y));
                end
            end
        end
    end

    // Receiver stalls at random
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Drive one word, with an optional idle gap first; valid stays up afterwards
    task automatic send_point(input coord_t px, input coord_t py, input coord_t cx,
                              input coord_t cy, input angle_t ang);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        point_x   = px;
        point_y   = py;
        center_x  = cx;
        center_y  = cy;
        angle_deg = ang;
        in_valid  = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic wait_results_drained();
        in_valid = 1'b0;
        while (rotated_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic coord_t small_coord();
        return coord_t'(int'($urandom_range(0, 16383)) - 8192);
    endfunction

    function automatic angle_t random_angle();
        case ($urandom_range(0, 3))
            0: return angle_t'($urandom);
            1: return angle_t'(int'($urandom_range(0, 184320)) - 92160);
            // near a quadrant boundary, a few multiples out
            2: return angle_t'((int'($urandom_range(0, 10)) - 5) * 23040
                               + int'($urandom_range(0, 4)) - 2);
            default: return angle_t'(int'($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    // Extremes of each coordinate field
    task automatic test_field_extremes();
        send_point('0, '0, '0, '0, '0);
        send_point(24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, '0);
        send_point(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 18'sd46080);
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 18'sd12345);
        send_point(24'sh800000, 24'sh800000, '0, '0, 18'sd5760);
        send_point(24'sh000001, 24'sh000100, '0, '0, -18'sd5760);
    endtask

    // Wrap past +-360, exact quadrant bounds, half-turn folding
    task automatic test_angle_special_cases();
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, 18'sd23040);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, -18'sd23040);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, 18'sd23041);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, -18'sd23041);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, 18'sd46080);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, -18'sd46080);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, 18'sd69120);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, 18'sd92160);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, -18'sd92160);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, 18'sd92161);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, 18'sh1FFFF);
        send_point(24'sd25600, 24'sd12800, 24'sd256, -24'sd512, 18'sh20000);
    endtask

    // Sums past either bound clamp
    task automatic test_saturation();
        send_point(24'sh800000, '0, 24'sh7FFFFF, '0, 18'sd46080);
        send_point(24'sh7FFFFF, '0, 24'sh800000, '0, 18'sd46080);
        send_point(24'sh7FFFFF, '0, '0, 24'sh7FFFFF, 18'sd23040);
        send_point(24'sh800000, '0, '0, 24'sh800000, 18'sd23040);
        send_point('0, 24'sh7FFFFF, 24'sh7FFFFF, '0, -18'sd23040);
    endtask

    // Hold the sender off until the pipeline has emptied, then resume
    task automatic test_drain_pause();
        repeat (8)
            send_point(small_coord(), small_coord(), small_coord(), small_coord(),
                       random_angle());
        wait_results_drained();
        repeat (8)
            send_point(small_coord(), small_coord(), small_coord(), small_coord(),
                       random_angle());
    endtask

    // Mostly points near the center, some full-range words for saturation
    task automatic test_random_traffic(input int count);
        coord_t cx;
        coord_t cy;
        coord_t px;
        coord_t py;
        int     pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            cx = ($urandom_range(0, 99) < 30) ? coord_t'($urandom) : small_coord();
            cy = ($urandom_range(0, 99) < 30) ? coord_t'($urandom) : small_coord();
            if (pick < 60)
            begin
                px = cx + small_coord();
                py = cy + small_coord();
            end
            else if (pick < 80)
            begin
                px = coord_t'($urandom);
                py = coord_t'($urandom);
            end
            else
            begin
                px = small_coord();
                py = small_coord();
            end
            send_point(px, py, cx, cy, random_angle());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // sender idles a little, receiver a lot
        send_idle_pct = 15;
        stall_pct     = 57;
        test_field_extremes();
        test_angle_special_cases();
        test_saturation();
        test_random_traffic(620);

        // sender idles a lot, receiver a little
        send_idle_pct = 57;
        stall_pct     = 15;
        test_drain_pause();
        test_random_traffic(620);

        // back to back, no idling
        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_traffic(620);

        wait_results_drained();
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Sent %0d points (field extremes, wraps past +-360, quadrant folds,",
                 words_sent);
        $display("saturation, drain pause) under three idle mixes; %0d results checked.",
                 results_seen);
        if (error_count == 0 && rotated_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
sv/prc_pkg.sv
sv/prc_prep.sv
sv/prc_cell.sv
sv/prc_post.sv
sv/point_rotate_about_center.sv
test/testbench.sv
